// File: rtl/cmf_pkg.sv
`default_nettype none

package cmf_pkg;

    localparam int MAX_PAIRS = 64;
    localparam int BURST_MAX = 12;
    localparam int CNT_W     = $clog2(BURST_MAX + 1);

    localparam logic [7:0] SYNC_ONE    = 8'hB5;
    localparam logic [7:0] SYNC_TWO    = 8'h62;
    localparam logic [7:0] CLASS_CFG   = 8'h06;
    localparam logic [7:0] ID_VALSET   = 8'h8A;
    localparam logic [7:0] TRANSACTION = 8'h00;
    localparam logic [7:0] VERSION     = 8'h00;
    localparam logic [7:0] RESERVED    = 8'h00;

    localparam logic [7:0]  LAYERS_RESET    = 8'd1;
    localparam logic [15:0] MAX_FRAME_RESET = 16'hFFFF;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_PAIR   = 1'b1;

    typedef enum logic [0:0] {
        REG_LAYERS    = 1'b0,
        REG_MAX_FRAME = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        mode;
        logic [6:0]  pair_count;
        logic [31:0] key_id;
        logic [7:0]  value_byte;
    } t_item;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_MAX-1:0]      last;
        logic [CNT_W-1:0]          cnt;
        logic                      rej;
        logic [8:0]                len;
    } t_burst;

endpackage

`default_nettype wire

// File: rtl/cmf_builder.sv
`default_nettype none

module cmf_builder
    import cmf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_load,
    input  wire t_item       i_item,
    output t_burst           o_burst
);

    logic [7:0]  r_layers, n_layers;
    logic [15:0] r_max_frame, n_max_frame;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [6:0]  r_pairs_left, n_pairs_left;
    logic        r_dropping, n_dropping;
    logic [8:0]  r_total, n_total;

    logic [9:0]  w_payload;
    logic [10:0] w_length;
    logic        w_too_long;
    logic [7:0]  w_hdr [8];
    logic [7:0]  w_pair [5];
    logic [7:0]  sa, sb;
    t_burst      b;

    assign w_payload  = 10'd4 + 10'(i_item.pair_count) * 10'd5;
    assign w_length   = 11'(w_payload) + 11'd8;
    assign w_too_long = (32'(i_item.pair_count) > MAX_PAIRS)
                     || ({5'b0, w_length} > r_max_frame);

    assign w_hdr[0] = CLASS_CFG;
    assign w_hdr[1] = ID_VALSET;
    assign w_hdr[2] = w_payload[7:0];
    assign w_hdr[3] = {6'b0, w_payload[9:8]};
    assign w_hdr[4] = VERSION;
    assign w_hdr[5] = r_layers;
    assign w_hdr[6] = TRANSACTION;
    assign w_hdr[7] = RESERVED;

    assign w_pair[0] = i_item.key_id[7:0];
    assign w_pair[1] = i_item.key_id[15:8];
    assign w_pair[2] = i_item.key_id[23:16];
    assign w_pair[3] = i_item.key_id[31:24];
    assign w_pair[4] = i_item.value_byte;

    always_comb begin
        b            = '0;
        sa           = r_sum_a;
        sb           = r_sum_b;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_pairs_left = r_pairs_left;
        n_dropping   = r_dropping;
        n_total      = r_total;
        if (i_item.mode == MODE_HEADER) begin
            n_pairs_left = i_item.pair_count;
            n_total      = w_length[8:0];
            sa           = '0;
            sb           = '0;
            if (w_too_long) begin
                n_dropping = 1'b1;
                b.cnt      = CNT_W'(1);
                b.last[0]  = 1'b1;
                b.rej      = 1'b1;
            end else begin
                n_dropping = 1'b0;
                b.bytes[0] = SYNC_ONE;
                b.bytes[1] = SYNC_TWO;
                for (int i = 0; i < 8; i++) begin
                    b.bytes[i+2] = w_hdr[i];
                    sa = sa + w_hdr[i];
                    sb = sb + sa;
                end
                b.cnt = CNT_W'(10);
                if (i_item.pair_count == 7'd0) begin
                    b.bytes[10] = sa;
                    b.bytes[11] = sb;
                    b.last[11]  = 1'b1;
                    b.len       = w_length[8:0];
                    b.cnt       = CNT_W'(12);
                end
            end
            n_sum_a = sa;
            n_sum_b = sb;
        end else if (r_pairs_left != 7'd0) begin
            n_pairs_left = r_pairs_left - 7'd1;
            if (r_dropping) begin
                if (n_pairs_left == 7'd0) begin
                    n_dropping = 1'b0;
                end
            end else begin
                for (int i = 0; i < 5; i++) begin
                    b.bytes[i] = w_pair[i];
                    sa = sa + w_pair[i];
                    sb = sb + sa;
                end
                b.cnt = CNT_W'(5);
                if (n_pairs_left == 7'd0) begin
                    b.bytes[5] = sa;
                    b.bytes[6] = sb;
                    b.last[6]  = 1'b1;
                    b.len      = r_total;
                    b.cnt      = CNT_W'(7);
                end
                n_sum_a = sa;
                n_sum_b = sb;
            end
        end
    end

    assign o_burst = b;

    always_comb begin
        n_layers    = r_layers;
        n_max_frame = r_max_frame;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LAYERS:    n_layers    = i_cfg_data[7:0];
                REG_MAX_FRAME: n_max_frame = i_cfg_data;
                default:       n_layers    = r_layers;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers     <= LAYERS_RESET;
            r_max_frame  <= MAX_FRAME_RESET;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_pairs_left <= '0;
            r_dropping   <= 1'b0;
            r_total      <= '0;
        end else begin
            r_layers    <= n_layers;
            r_max_frame <= n_max_frame;
            if (i_load) begin
                r_sum_a      <= n_sum_a;
                r_sum_b      <= n_sum_b;
                r_pairs_left <= n_pairs_left;
                r_dropping   <= n_dropping;
                r_total      <= n_total;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/config_message_framer_top.sv
// channel   dir  handshake                           payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready    tdata: pair_count, key_id, value_byte
//                                                     tuser: mode
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready    tdata: frame_byte, frame_bytes
//                                                     tlast: last, tuser: rejected
// cfg       in   i_cfg_we                             i_cfg_idx, i_cfg_data
//
// one byte leaves per cycle unless the output stalls: a pair item sends 5 bytes (7 with
// the checksum), a header 10 (12 for zero pairs), a rejected header 1, an empty item none
// the output byte rate sets the item rate; first byte passes r_in, r_bytes and r_out_byte
// synchronous active-low reset clears handshakes and frame state, presets config registers
// a stalled output keeps one item queued ahead of the byte buffer
`default_nettype none

module config_message_framer_top
    import cmf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // pair_count, key_id, value_byte
    input  wire logic        i_s_axis_tuser,   // mode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // frame_byte, frame_bytes
    output logic             o_m_axis_tlast,
    output logic             o_m_axis_tuser    // rejected
);

    logic                      r_in_valid, n_in_valid;
    t_item                     r_in;
    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [BURST_MAX-1:0]      r_last;
    logic                      r_rej;
    logic [8:0]                r_len;
    logic [CNT_W-1:0]          r_rem, n_rem;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;
    logic                      r_out_rej;
    logic [8:0]                r_out_len;

    logic   w_accept, w_pop, w_buf_free, w_load;
    t_burst w_burst;

    assign w_pop      = (r_rem != '0) && (!r_out_valid || i_m_axis_tready);
    assign w_buf_free = (r_rem == '0) || ((r_rem == CNT_W'(1)) && w_pop);
    assign w_load     = r_in_valid && w_buf_free;
    assign o_s_axis_tready = !r_in_valid || w_buf_free;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    cmf_builder u_builder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_load     (w_load),
        .i_item     (r_in),
        .o_burst    (w_burst)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_load) begin
            n_in_valid = 1'b0;
        end
        n_rem = r_rem;
        if (w_load) begin
            n_rem = w_burst.cnt;
        end else if (w_pop) begin
            n_rem = r_rem - CNT_W'(1);
        end
        n_out_valid = r_out_valid;
        if (w_pop) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.mode       <= i_s_axis_tuser;
            r_in.pair_count <= i_s_axis_tdata[6:0];
            r_in.key_id     <= i_s_axis_tdata[38:7];
            r_in.value_byte <= i_s_axis_tdata[46:39];
        end
        if (w_load) begin
            r_bytes <= w_burst.bytes;
            r_last  <= w_burst.last;
            r_rej   <= w_burst.rej;
            r_len   <= w_burst.len;
        end else if (w_pop) begin
            r_bytes <= {8'h00, r_bytes[BURST_MAX-1:1]};
            r_last  <= {1'b0, r_last[BURST_MAX-1:1]};
        end
        if (w_pop) begin
            r_out_byte <= r_bytes[0];
            r_out_last <= r_last[0];
            r_out_rej  <= r_last[0] && r_rej;
            r_out_len  <= (r_last[0] && !r_rej) ? r_len : 9'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_len, r_out_byte};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_rej;

    a_rej_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("rejected item without last");

    a_len_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast && !o_m_axis_tuser
        |-> o_m_axis_tdata[16:8] != 9'd0)
        else $error("final checksum byte without frame length");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_rem == '0) || (r_rem == CNT_W'(1) && w_pop))
        else $error("burst loaded over pending bytes");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= CNT_W'(BURST_MAX))
        else $error("byte buffer count out of range");

endmodule

`default_nettype wire
